>>> rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VT4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vt4 assertion failed");

// next-cycle implication, disabled while reset is asserted
`define VT4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vt4 assertion failed");

`endif

>>> rtl/vt4_pkg.sv
// shared types and constants for the 4x4 vertex transform
`timescale 1ns / 1ps
`default_nettype none

package vt4_pkg;

	// number format
	localparam int COMPONENT_WIDTH = 32;
	localparam int FRAC_BITS       = 16;

	// port and register geometry
	localparam int OUT_W       = 32;
	localparam int HALF_W      = 32;
	localparam int REG_W       = 2 * HALF_W;
	localparam int NUM_COMP    = 4;
	localparam int NUM_REGS    = 8;
	localparam int REG_IDX_W   = $clog2(NUM_REGS);
	localparam int CFG_INDEX_W = REG_IDX_W + 1;

	// datapath widths: product, pair sum, full sum
	localparam int PROD_W = 2 * COMPONENT_WIDTH;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
	typedef logic signed [OUT_W-1:0]           out_t;
	typedef logic signed [PROD_W-1:0]          prod_t;
	typedef logic signed [PAIR_W-1:0]          pair_t;
	typedef logic signed [SUM_W-1:0]           sum_t;
	typedef logic [REG_W-1:0]                  mat_reg_t;

	// saturation bounds
	localparam comp_t COMP_MAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
	localparam comp_t COMP_MIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
	localparam out_t  OUT_MAX  = OUT_W'(COMP_MAX);
	localparam out_t  OUT_MIN  = OUT_W'(COMP_MIN);

	// identity matrix in Q format: one element per half register
	localparam logic [HALF_W-1:0] FIX_ONE  = HALF_W'(1) << FRAC_BITS;
	localparam logic [HALF_W-1:0] FIX_ZERO = '0;
	localparam mat_reg_t MAT_RESET [NUM_REGS] = '{
		{FIX_ZERO, FIX_ONE},  {FIX_ZERO, FIX_ZERO},
		{FIX_ONE,  FIX_ZERO}, {FIX_ZERO, FIX_ZERO},
		{FIX_ZERO, FIX_ZERO}, {FIX_ZERO, FIX_ONE},
		{FIX_ZERO, FIX_ZERO}, {FIX_ONE,  FIX_ZERO}
	};

	// per-stage load enables from the pipeline control
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} stage_en_t;

endpackage

`default_nettype wire

>>> rtl/vt4_column.sv
// one output column: four multiplies, adder tree, floor shift and saturation
`timescale 1ns / 1ps
`default_nettype none

module vt4_column (
	input  wire logic              clk,
	input  wire vt4_pkg::stage_en_t en,
	input  wire vt4_pkg::comp_t    vec  [vt4_pkg::NUM_COMP],
	input  wire vt4_pkg::comp_t    elem [vt4_pkg::NUM_COMP],
	output vt4_pkg::comp_t         res,
	output logic                   sat
);

	vt4_pkg::prod_t prod_s1 [vt4_pkg::NUM_COMP];
	vt4_pkg::pair_t pair_s2 [2];
	vt4_pkg::sum_t  sh_s3;
	vt4_pkg::comp_t res_s4;
	logic           sat_s4;
	vt4_pkg::sum_t  sum_full;
	logic           sat_hi;
	logic           sat_lo;

	// stage 1: one signed multiply per row
	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			for (int i = 0; i < vt4_pkg::NUM_COMP; i++) begin
				prod_s1[i] <= vt4_pkg::prod_t'(vec[i]) * vt4_pkg::prod_t'(elem[i]);
			end
		end
	end

	// stage 2: pairwise sums
	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			pair_s2[0] <= vt4_pkg::pair_t'(prod_s1[0]) + vt4_pkg::pair_t'(prod_s1[1]);
			pair_s2[1] <= vt4_pkg::pair_t'(prod_s1[2]) + vt4_pkg::pair_t'(prod_s1[3]);
		end
	end

	// stage 3: exact full sum, then arithmetic shift (floor)
	assign sum_full = vt4_pkg::sum_t'(pair_s2[0]) + vt4_pkg::sum_t'(pair_s2[1]);

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			sh_s3 <= sum_full >>> vt4_pkg::FRAC_BITS;
		end
	end

	// stage 4: clamp when the upper bits are not a plain sign extension
	assign sat_hi = !sh_s3[vt4_pkg::SUM_W-1] &&
		(|sh_s3[vt4_pkg::SUM_W-2:vt4_pkg::COMPONENT_WIDTH-1]);
	assign sat_lo = sh_s3[vt4_pkg::SUM_W-1] &&
		!(&sh_s3[vt4_pkg::SUM_W-2:vt4_pkg::COMPONENT_WIDTH-1]);

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			if (sat_hi) begin
				res_s4 <= vt4_pkg::COMP_MAX;
			end else if (sat_lo) begin
				res_s4 <= vt4_pkg::COMP_MIN;
			end else begin
				res_s4 <= sh_s3[vt4_pkg::COMPONENT_WIDTH-1:0];
			end
			sat_s4 <= sat_hi || sat_lo;
		end
	end

	assign res = res_s4;
	assign sat = sat_s4;

endmodule

`default_nettype wire

>>> rtl/vertex_transform_4x4_top.sv
// top level of the 4x4 homogeneous vertex transform
// Transforms one row vector (x, y, z, w) in signed Q16.16 by the 4x4 matrix held
// in eight 64-bit configuration registers (reset to identity); each output is
// the dot product with one matrix column, summed exactly, floored by the
// fraction width and saturated, with overflow set when any component clamps.
// Throughput is one vector per cycle while in_stall is low; each column unit has
// four register stages: multiply, pair add, final add with
// shift, saturate. The pipeline collapses bubbles, so in_stall rises only when
// all four stages hold data and the output is stalled. Configuration writes are
// always taken (cfg_ready is tied high) and must occur while the pipe is empty;
// writes to an index above 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_4x4_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// vector input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [31:0]                 vec_x,
	input  wire logic signed [31:0]                 vec_y,
	input  wire logic signed [31:0]                 vec_z,
	input  wire logic signed [31:0]                 vec_w,
	// result output channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [vt4_pkg::OUT_W-1:0]        out_x,
	output logic signed [vt4_pkg::OUT_W-1:0]        out_y,
	output logic signed [vt4_pkg::OUT_W-1:0]        out_z,
	output logic signed [vt4_pkg::OUT_W-1:0]        out_w,
	output logic                                    overflow,
	// configuration write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [vt4_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [vt4_pkg::REG_W-1:0]          cfg_data
);

	vt4_pkg::mat_reg_t  mat_q [vt4_pkg::NUM_REGS];
	vt4_pkg::comp_t     vec   [vt4_pkg::NUM_COMP];
	vt4_pkg::comp_t     col_elem [vt4_pkg::NUM_COMP][vt4_pkg::NUM_COMP];
	vt4_pkg::comp_t     col_res  [vt4_pkg::NUM_COMP];
	logic [vt4_pkg::NUM_COMP-1:0] col_sat;
	vt4_pkg::stage_en_t en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	// matrix registers, written one 64-bit row half-pair per transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < vt4_pkg::NUM_REGS; r++) begin
				mat_q[r] <= vt4_pkg::MAT_RESET[r];
			end
		end else if (cfg_valid && cfg_ready &&
				cfg_index < vt4_pkg::CFG_INDEX_W'(vt4_pkg::NUM_REGS)) begin
			mat_q[cfg_index[vt4_pkg::REG_IDX_W-1:0]] <= cfg_data;
		end
	end

	// only the low component bits of each input are used
	assign vec[0] = vec_x[vt4_pkg::COMPONENT_WIDTH-1:0];
	assign vec[1] = vec_y[vt4_pkg::COMPONENT_WIDTH-1:0];
	assign vec[2] = vec_z[vt4_pkg::COMPONENT_WIDTH-1:0];
	assign vec[3] = vec_w[vt4_pkg::COMPONENT_WIDTH-1:0];

	// pipeline control: a stage loads when empty or when its successor moves
	assign ready_s4 = !valid_s4 || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	assign en.ld_s1 = in_valid && ready_s1;
	assign en.ld_s2 = valid_s1 && ready_s2;
	assign en.ld_s3 = valid_s2 && ready_s3;
	assign en.ld_s4 = valid_s3 && ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// column units: column c takes element (r, c) from register 2r + c/2
	for (genvar c = 0; c < vt4_pkg::NUM_COMP; c++) begin : g_col
		for (genvar r = 0; r < vt4_pkg::NUM_COMP; r++) begin : g_row
			assign col_elem[c][r] =
				mat_q[r * 2 + c / 2][(c % 2) * vt4_pkg::HALF_W +: vt4_pkg::COMPONENT_WIDTH];
		end

		vt4_column u_column (
			.clk  (clk),
			.en   (en),
			.vec  (vec),
			.elem (col_elem[c]),
			.res  (col_res[c]),
			.sat  (col_sat[c])
		);
	end

	// results, sign-extended to the port width
	assign out_valid = valid_s4;
	assign out_x     = vt4_pkg::OUT_W'(col_res[0]);
	assign out_y     = vt4_pkg::OUT_W'(col_res[1]);
	assign out_z     = vt4_pkg::OUT_W'(col_res[2]);
	assign out_w     = vt4_pkg::OUT_W'(col_res[3]);
	assign overflow  = |col_sat;

endmodule

`default_nettype wire

>>> rtl/vt4_checker.sv
// port-level checker for the vertex transform, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vt4_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_stall,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic signed [vt4_pkg::OUT_W-1:0]   out_x,
	input wire logic signed [vt4_pkg::OUT_W-1:0]   out_y,
	input wire logic signed [vt4_pkg::OUT_W-1:0]   out_z,
	input wire logic signed [vt4_pkg::OUT_W-1:0]   out_w,
	input wire logic                               overflow
);

	// a stalled result holds until its transfer
	`VT4_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_w) && $stable(overflow))

	// input backpressure only when the whole pipe is full behind a stalled output
	`VT4_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, out_valid && out_stall)

	// overflow means at least one component sits at a bound
	`VT4_ASSERT_NOW(a_ovf_clamped, clk, arst_n, out_valid && overflow, out_x == vt4_pkg::OUT_MAX || out_x == vt4_pkg::OUT_MIN || out_y == vt4_pkg::OUT_MAX || out_y == vt4_pkg::OUT_MIN || out_z == vt4_pkg::OUT_MAX || out_z == vt4_pkg::OUT_MIN || out_w == vt4_pkg::OUT_MAX || out_w == vt4_pkg::OUT_MIN)

endmodule

bind vertex_transform_4x4_top vt4_checker u_vt4_checker (.*);

`default_nettype wire
